FILE: sv/knns_pkg.sv
// knns_pkg: shared types and constants of the two-level k-nearest selector
// holds payload structs, list entry type, state enums and code constants
// no dependencies
package knns_pkg;

   localparam int COORD_BITS = 16;
   localparam int ID_BITS    = 16;
   localparam int DIST_BITS  = 34;
   localparam int CNT_BITS   = 5;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int CSR_IDX_BITS = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_BITS-1:0] CSR_QUERY_X = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_QUERY_Y = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_QUERY_Z = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEEP    = 2'd3;

   localparam logic [CNT_BITS-1:0] KEEP_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_CLEAR_PASS = 2'd0,
      OP_CLEAR_ALL  = 2'd1,
      OP_OFFER      = 2'd2,
      OP_DRAIN      = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type                   opcode;
      logic signed [COORD_BITS-1:0] cand_x;
      logic signed [COORD_BITS-1:0] cand_y;
      logic signed [COORD_BITS-1:0] cand_z;
      logic [ID_BITS-1:0]           point_id;
   } req_type;

   typedef struct packed {
      logic                 pass_accepted;
      logic                 overall_accepted;
      logic [CNT_BITS-1:0]  pass_count;
      logic [CNT_BITS-1:0]  overall_count;
      logic                 entry_valid;
      logic [ID_BITS-1:0]   out_id;
      logic [DIST_BITS-1:0] out_distance;
      logic                 last;
   } rsp_type;

   // one stored list entry
   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic [ID_BITS-1:0]   id;
   } entry_type;

   typedef enum logic [1:0] {
      LS_IDLE,
      LS_TAIL,
      LS_SCAN,
      LS_PLACE
   } list_state_type;

   typedef enum logic [2:0] {
      TS_IDLE,
      TS_DIST,
      TS_START,
      TS_PASS,
      TS_BEST,
      TS_REPLY,
      TS_DRAIN,
      TS_DEND
   } top_state_type;

endpackage

FILE: sv/knns_list.sv
// knns_list: one sorted candidate list held in a synchronous memory
// inserts by scanning from the tail, one shift per cycle; depends on knns_pkg
module knns_list #(
   parameter int MAX_KEEP = 16,
   localparam int FW = $clog2(MAX_KEEP + 1),
   localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ins_start,
   input  logic [knns_pkg::DIST_BITS-1:0] ins_dist,
   input  logic [knns_pkg::ID_BITS-1:0]   ins_id,
   input  logic [FW-1:0]                 lim,
   input  logic                          clear,
   input  logic [AW-1:0]                 rd_addr,
   output knns_pkg::entry_type           rd_data,
   output logic                          ins_done,
   output logic                          ins_taken,
   output logic [FW-1:0]                 fill
);
   import knns_pkg::*;

   entry_type      mem [MAX_KEEP];
   entry_type      rdata_ff;
   list_state_type state_ff, state_in;
   logic [FW-1:0]  pos_ff, pos_in;
   logic [FW-1:0]  base_ff, base_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [DIST_BITS-1:0] dist_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic           done_ff, taken_ff;

   logic           full, tail_hit, scan_move;
   logic [AW-1:0]  raddr, waddr;
   logic           we, done, taken;
   entry_type      wdata, fresh;
   logic [FW-1:0]  base_cur;

   assign full      = fill_ff >= lim;
   assign tail_hit  = dist_ff < rdata_ff.distance;
   assign scan_move = rdata_ff.distance > dist_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LS_IDLE: begin
            if (ins_start && fill_ff != '0) state_in = full ? LS_TAIL : LS_SCAN;
         end
         LS_TAIL: begin
            state_in = (tail_hit && base_ff != '0) ? LS_SCAN : LS_IDLE;
         end
         LS_SCAN: begin
            if (!scan_move) state_in = LS_IDLE;
            else if (pos_ff == FW'(1)) state_in = LS_PLACE;
         end
         LS_PLACE: state_in = LS_IDLE;
         default:  state_in = LS_IDLE;
      endcase
   end

   // memory ports and completion
   always_comb begin
      raddr = rd_addr;
      we    = 1'b0;
      waddr = '0;
      fresh = '{distance: dist_ff, id: id_ff};
      wdata = fresh;
      done  = 1'b0;
      taken = 1'b0;
      case (state_ff)
         LS_IDLE: begin
            if (ins_start) begin
               raddr = AW'(fill_ff - FW'(1));
               if (fill_ff == '0) begin
                  we    = 1'b1;
                  wdata = '{distance: ins_dist, id: ins_id};
                  done  = 1'b1;
                  taken = 1'b1;
               end
            end
         end
         LS_TAIL: begin
            if (!tail_hit) begin
               done = 1'b1;
            end else if (base_ff == '0) begin
               we    = 1'b1;
               done  = 1'b1;
               taken = 1'b1;
            end else begin
               raddr = AW'(base_ff - FW'(1));
            end
         end
         LS_SCAN: begin
            waddr = AW'(pos_ff);
            we    = 1'b1;
            if (scan_move) begin
               wdata = rdata_ff;
               raddr = AW'(pos_ff - FW'(2));
            end else begin
               done  = 1'b1;
               taken = 1'b1;
            end
         end
         LS_PLACE: begin
            we    = 1'b1;
            done  = 1'b1;
            taken = 1'b1;
         end
         default: ;
      endcase
   end

   // working registers
   assign base_cur = (state_ff == LS_IDLE) ? fill_ff : base_ff;

   always_comb begin
      pos_in  = pos_ff;
      base_in = base_ff;
      fill_in = fill_ff;
      if (state_ff == LS_IDLE && ins_start) begin
         base_in = full ? fill_ff - FW'(1) : fill_ff;
         pos_in  = base_in;
      end else if (state_ff == LS_SCAN && scan_move) begin
         pos_in = pos_ff - FW'(1);
      end
      if (clear) fill_in = '0;
      else if (done && taken) fill_in = base_cur + FW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_IDLE;
         fill_ff  <= '0;
         done_ff  <= 1'b0;
         taken_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         done_ff  <= done;
         taken_ff <= taken;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      base_ff <= base_in;
      if (state_ff == LS_IDLE && ins_start) begin
         dist_ff <= ins_dist;
         id_ff   <= ins_id;
      end
   end

   // list memory: scan writes entry pos while reading pos-2, so no overlap
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rd_data   = rdata_ff;
   assign ins_done  = done_ff;
   assign ins_taken = taken_ff;
   assign fill      = fill_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_KEEP))
      else $error("list fill above capacity");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == LS_IDLE)
      else $error("list done while still inserting");
   a_taken_done: assert property (@(posedge clock) disable iff (reset)
      taken_ff |-> done_ff)
      else $error("list taken without done");
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (!clear && state_ff != LS_IDLE) |=> fill_ff >= $past(fill_ff))
      else $error("list fill dropped during insert");
`endif

endmodule

FILE: sv/two_level_k_nearest_selector_unit.sv
// two_level_k_nearest_selector_unit: top level of the k-nearest selector
// pass and overall lists in knns_list memories; depends on knns_pkg, knns_list
//
//  channel  ports                          transfer
//  request  start, busy, req_data          start high while busy low
//  result   rsp_valid, rsp_data            every cycle rsp_valid is high
//  config   csr_we, csr_index, csr_wdata   every cycle csr_we is high
//
// clear: a single reply. offer: the distance is registered, then the pass list and, if
// taken there, the overall list insert it (at once when empty, else scanning from the
// tail), then a reply. drain: one memory read per entry through the overall list port.
// synchronous reset empties both lists; list entries need no clearing.
// results go out one per cycle with no stall from the receiver.
module two_level_k_nearest_selector_unit #(
   parameter int MAX_KEEP = 16,
   parameter int DIMS     = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  knns_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   output knns_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [knns_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [knns_pkg::COORD_BITS-1:0]    csr_wdata
);
   import knns_pkg::*;

   localparam int FW = $clog2(MAX_KEEP + 1);
   localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

   top_state_type state_ff, state_in;
   logic [COORD_BITS-1:0] qx_ff, qy_ff, qz_ff;
   logic [CNT_BITS-1:0]   keep_ff;
   logic [FW-1:0]         lim;

   logic [ID_BITS-1:0]    id_ff;
   logic [SQ_BITS-1:0]    sq_ff [3];
   logic [SQ_BITS-1:0]    sq_in [3];
   logic                  same_ff, same_in;
   logic [DIST_BITS-1:0]  dist_ff;
   logic                  pa_ff, oa_ff;
   logic [FW-1:0]         cnt_ff, idx_ff, emit_idx_ff;
   logic                  emit_ff;

   logic                  accept;
   logic                  pass_start, best_start, pass_clear, best_clear;
   logic                  pass_done, pass_taken, best_done, best_taken;
   logic [FW-1:0]         pass_fill, best_fill;
   entry_type             pass_rd, best_rd;

   assign accept = start && !busy;
   assign busy   = state_ff != TS_IDLE;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         qx_ff   <= '0;
         qy_ff   <= '0;
         qz_ff   <= '0;
         keep_ff <= KEEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_QUERY_X: qx_ff   <= csr_wdata;
            CSR_QUERY_Y: qy_ff   <= csr_wdata;
            CSR_QUERY_Z: qz_ff   <= csr_wdata;
            CSR_KEEP:    keep_ff <= csr_wdata[CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // capacity clamped to 1..MAX_KEEP
   always_comb begin
      if (keep_ff == '0) lim = FW'(1);
      else if (int'(keep_ff) > MAX_KEEP) lim = FW'(MAX_KEEP);
      else lim = FW'(keep_ff);
   end

   // per-axis squared difference, one multiplier each
   always_comb begin
      logic signed [COORD_BITS-1:0] cv [3];
      logic signed [COORD_BITS-1:0] qv [3];
      logic signed [COORD_BITS:0]   diff;
      logic [COORD_BITS:0]          mag;
      cv[0] = req_data.cand_x;
      cv[1] = req_data.cand_y;
      cv[2] = req_data.cand_z;
      qv[0] = qx_ff;
      qv[1] = qy_ff;
      qv[2] = qz_ff;
      same_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         diff = (COORD_BITS + 1)'(cv[i]) - (COORD_BITS + 1)'(qv[i]);
         mag  = diff[COORD_BITS] ? -diff : diff;
         if (i < DIMS) begin
            sq_in[i] = mag[COORD_BITS-1:0] * mag[COORD_BITS-1:0];
            if (cv[i] != qv[i]) same_in = 1'b0;
         end else begin
            sq_in[i] = '0;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TS_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  OP_OFFER: state_in = TS_DIST;
                  OP_DRAIN: state_in = (best_fill == '0) ? TS_REPLY : TS_DRAIN;
                  default:  state_in = TS_REPLY;
               endcase
            end
         end
         TS_DIST:  state_in = TS_START;
         TS_START: state_in = same_ff ? TS_REPLY : TS_PASS;
         TS_PASS: begin
            if (pass_done) state_in = pass_taken ? TS_BEST : TS_REPLY;
         end
         TS_BEST: begin
            if (best_done) state_in = TS_REPLY;
         end
         TS_REPLY: state_in = TS_IDLE;
         TS_DRAIN: begin
            if (idx_ff == cnt_ff - FW'(1)) state_in = TS_DEND;
         end
         TS_DEND: state_in = TS_IDLE;
         default: state_in = TS_IDLE;
      endcase
   end

   // list control and result outputs
   always_comb begin
      pass_start = (state_ff == TS_START) && !same_ff;
      best_start = (state_ff == TS_PASS) && pass_done && pass_taken;
      pass_clear = accept && (req_data.opcode == OP_CLEAR_PASS ||
                              req_data.opcode == OP_CLEAR_ALL);
      best_clear = (accept && req_data.opcode == OP_CLEAR_ALL) ||
                   state_ff == TS_DEND;
      rsp_valid  = 1'b0;
      rsp_data   = '0;
      rsp_data.pass_count = CNT_BITS'(pass_fill);
      case (state_ff)
         TS_REPLY: begin
            rsp_valid = 1'b1;
            rsp_data.pass_accepted    = pa_ff;
            rsp_data.overall_accepted = oa_ff;
            rsp_data.overall_count    = CNT_BITS'(best_fill);
            rsp_data.last             = 1'b1;
         end
         TS_DRAIN, TS_DEND: begin
            rsp_valid = emit_ff;
            rsp_data.overall_count = CNT_BITS'(cnt_ff - FW'(1) - emit_idx_ff);
            rsp_data.entry_valid   = 1'b1;
            rsp_data.out_id        = best_rd.id;
            rsp_data.out_distance  = best_rd.distance;
            rsp_data.last          = emit_idx_ff == cnt_ff - FW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TS_IDLE;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         emit_ff  <= state_ff == TS_DRAIN;
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      if (accept) begin
         id_ff   <= req_data.point_id;
         same_ff <= same_in;
         sq_ff   <= sq_in;
         pa_ff   <= 1'b0;
         oa_ff   <= 1'b0;
         cnt_ff  <= best_fill;
         idx_ff  <= '0;
      end else begin
         if (state_ff == TS_PASS && pass_done) pa_ff <= pass_taken;
         if (state_ff == TS_BEST && best_done) oa_ff <= best_taken;
         if (state_ff == TS_DRAIN) idx_ff <= idx_ff + FW'(1);
      end
      if (state_ff == TS_DIST) begin
         dist_ff <= DIST_BITS'(sq_ff[0]) + DIST_BITS'(sq_ff[1]) + DIST_BITS'(sq_ff[2]);
      end
      emit_idx_ff <= idx_ff;
   end

   knns_list #(.MAX_KEEP(MAX_KEEP)) u_pass (
      .clock     (clock),
      .reset     (reset),
      .ins_start (pass_start),
      .ins_dist  (dist_ff),
      .ins_id    (id_ff),
      .lim       (lim),
      .clear     (pass_clear),
      .rd_addr   ('0),
      .rd_data   (pass_rd),
      .ins_done  (pass_done),
      .ins_taken (pass_taken),
      .fill      (pass_fill)
   );

   knns_list #(.MAX_KEEP(MAX_KEEP)) u_best (
      .clock     (clock),
      .reset     (reset),
      .ins_start (best_start),
      .ins_dist  (dist_ff),
      .ins_id    (id_ff),
      .lim       (lim),
      .clear     (best_clear),
      .rd_addr   (AW'(idx_ff)),
      .rd_data   (best_rd),
      .ins_done  (best_done),
      .ins_taken (best_taken),
      .fill      (best_fill)
   );

`ifndef SYNTHESIS
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_valid)
      else $error("result while idle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not start");
   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.entry_valid) |-> rsp_data.last)
      else $error("single reply without last");
   a_overall_sub: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overall_accepted) |-> rsp_data.pass_accepted)
      else $error("overall entry without pass entry");
   a_pass_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == TS_IDLE && pass_fill != '0) |-> !$isunknown(pass_rd))
      else $error("pass list head unknown while filled");
`endif

endmodule
